// File: hw/rtl/aism_pkg.sv
// Shared types, register indexes and constants of the address interleave slice matcher.
package aism_pkg;

	// defaults for top-level parameters
	localparam int DEF_ADDR_WIDTH = 64;
	localparam int DEF_MAX_SLICES = 256;

	// fixed field widths
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 3;
	localparam int STRIPE_W    = 32;
	localparam int COUNT_W     = 9;
	localparam int SLICE_W     = 8;
	localparam int SHIFT_W     = 6;
	localparam int MODE_W      = 2;
	localparam int KEY_W       = 64;

	// key bits consumed per modulo stage
	localparam int MOD_STEP = 4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_BASE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LIMIT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE        = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_SIZE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SLICE_COUNT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SLICE_INDEX = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_SHIFT  = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_HASH_SEED   = 3'd7;

	// interleave modes; the spare code behaves as linear
	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_XOR    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

	// register reset values
	localparam logic [STRIPE_W-1:0] RST_STRIPE_SIZE = 32'd4096;
	localparam logic [COUNT_W-1:0]  RST_SLICE_COUNT = 9'd1;

	// control that travels with each word down the pipe
	typedef struct packed {
		logic valid;
		logic in_window;
	} ctl_t;

endpackage

// File: hw/rtl/aism_div_pipe.sv
// Pipelined restoring divider: window offset over stripe size, one quotient bit per stage.
module aism_div_pipe #(
	parameter int ADDR_WIDTH = aism_pkg::DEF_ADDR_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  aism_pkg::ctl_t                ctl_in,
	input  logic [ADDR_WIDTH-1:0]         dividend,
	input  logic [aism_pkg::STRIPE_W-1:0] divisor,
	output aism_pkg::ctl_t                ctl_out,
	output logic [ADDR_WIDTH-1:0]         quotient
);

	localparam int DW = aism_pkg::STRIPE_W;

	// index k holds what enters stage k; index ADDR_WIDTH is the last register
	aism_pkg::ctl_t        ctl_s [ADDR_WIDTH+1];
	logic [DW-1:0]         rem_s [ADDR_WIDTH+1];
	logic [ADDR_WIDTH-1:0] dq_s  [ADDR_WIDTH+1];

	assign ctl_s[0] = ctl_in;
	assign rem_s[0] = '0;
	assign dq_s[0]  = dividend;

	for (genvar k = 0; k < ADDR_WIDTH; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          fits;
		logic [DW:0]   diff;
		logic [DW-1:0] rem_nxt;

		// shift in next dividend bit, subtract divisor if it fits
		assign trial   = {rem_s[k], dq_s[k][ADDR_WIDTH-1]};
		assign fits    = trial >= {1'b0, divisor};
		assign diff    = trial - {1'b0, divisor};
		assign rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (adv) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		// dividend bits leave at the top, quotient bits enter at the bottom
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= rem_nxt;
				dq_s[k+1]  <= {dq_s[k][ADDR_WIDTH-2:0], fits};
			end
		end
	end

	assign ctl_out  = ctl_s[ADDR_WIDTH];
	assign quotient = dq_s[ADDR_WIDTH];

endmodule

// File: hw/rtl/aism_mod_pipe.sv
// Pipelined modulo of the 64-bit slice key by the slice count, MOD_STEP key bits per stage.
module aism_mod_pipe #(
	parameter int MAX_SLICES = aism_pkg::DEF_MAX_SLICES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  aism_pkg::ctl_t                    ctl_in,
	input  logic [aism_pkg::KEY_W-1:0]        key,
	input  logic [$clog2(MAX_SLICES):0]       modulus,
	output aism_pkg::ctl_t                    ctl_out,
	output logic [$clog2(MAX_SLICES)-1:0]     remainder
);

	localparam int REM_W  = $clog2(MAX_SLICES);
	localparam int KW     = aism_pkg::KEY_W;
	localparam int STEP   = aism_pkg::MOD_STEP;
	localparam int STAGES = KW / STEP;

	aism_pkg::ctl_t ctl_s [STAGES+1];
	logic [REM_W-1:0] rem_s [STAGES+1];
	logic [KW-1:0]    key_s [STAGES+1];

	assign ctl_s[0] = ctl_in;
	assign rem_s[0] = '0;
	assign key_s[0] = key;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [REM_W-1:0] rem_nxt;
		logic [KW-1:0]    key_nxt;

		// STEP restoring steps on narrow remainder values
		always_comb begin
			logic [REM_W:0] trial;
			logic [REM_W:0] diff;
			rem_nxt = rem_s[k];
			key_nxt = key_s[k];
			for (int j = 0; j < STEP; j++) begin
				trial   = {rem_nxt, key_nxt[KW-1]};
				diff    = trial - modulus;
				key_nxt = {key_nxt[KW-2:0], 1'b0};
				if (trial >= modulus) begin
					rem_nxt = diff[REM_W-1:0];
				end else begin
					rem_nxt = trial[REM_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '0;
			end else if (adv) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= rem_nxt;
				key_s[k+1] <= key_nxt;
			end
		end
	end

	assign ctl_out   = ctl_s[STAGES];
	assign remainder = rem_s[STAGES];

endmodule

// File: hw/rtl/address_interleave_slice_match.sv
// Top level of the address interleave slice matcher: config registers, window, hash, output.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in      | in        | in_valid / in_stall  | address
//  out     | out       | out_valid / out_stall| in_window, owner_match, slice_number
//  cfg     | in        | cfg_write            | cfg_index, cfg_data
//
// One word enters per cycle while the pipe is not stalled; from acceptance each passes through one
// window stage, ADDR_WIDTH divider stages (one quotient bit each), one hash stage, 16 modulo
// stages (four key bits each) and the output register.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// A stalled output word freezes the whole pipe, and in_stall follows at once.
module address_interleave_slice_match #(
	parameter int ADDR_WIDTH = aism_pkg::DEF_ADDR_WIDTH,
	parameter int MAX_SLICES = aism_pkg::DEF_MAX_SLICES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_write,
	input  logic [aism_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [aism_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [ADDR_WIDTH-1:0]            address,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             in_window,
	output logic                             owner_match,
	output logic [aism_pkg::SLICE_W-1:0]     slice_number
);

	localparam int REM_W = $clog2(MAX_SLICES);
	localparam int CNT_W = REM_W + 1;
	localparam int KW    = aism_pkg::KEY_W;

	// configuration registers
	logic [ADDR_WIDTH-1:0]              range_base_q;
	logic [ADDR_WIDTH-1:0]              range_limit_q;
	logic [aism_pkg::MODE_W-1:0]        mode_q;
	logic [aism_pkg::STRIPE_W-1:0]      stripe_size_q;
	logic [aism_pkg::COUNT_W-1:0]       slice_count_q;
	logic [aism_pkg::SLICE_W-1:0]       slice_index_q;
	logic [aism_pkg::SHIFT_W-1:0]       hash_shift_q;
	logic [KW-1:0]                      hash_seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_base_q  <= '0;
			range_limit_q <= '0;
			mode_q        <= aism_pkg::MODE_OFF;
			stripe_size_q <= aism_pkg::RST_STRIPE_SIZE;
			slice_count_q <= aism_pkg::RST_SLICE_COUNT;
			slice_index_q <= '0;
			hash_shift_q  <= '0;
			hash_seed_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				aism_pkg::REG_RANGE_BASE:  range_base_q  <= cfg_data[ADDR_WIDTH-1:0];
				aism_pkg::REG_RANGE_LIMIT: range_limit_q <= cfg_data[ADDR_WIDTH-1:0];
				aism_pkg::REG_MODE:        mode_q        <= cfg_data[aism_pkg::MODE_W-1:0];
				aism_pkg::REG_STRIPE_SIZE: stripe_size_q <= cfg_data[aism_pkg::STRIPE_W-1:0];
				aism_pkg::REG_SLICE_COUNT: slice_count_q <= cfg_data[aism_pkg::COUNT_W-1:0];
				aism_pkg::REG_SLICE_INDEX: slice_index_q <= cfg_data[aism_pkg::SLICE_W-1:0];
				aism_pkg::REG_HASH_SHIFT:  hash_shift_q  <= cfg_data[aism_pkg::SHIFT_W-1:0];
				aism_pkg::REG_HASH_SEED:   hash_seed_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// effective divisor and slice count; user keeps config static while words are in flight (not enforced)
	logic [aism_pkg::STRIPE_W-1:0] divisor;
	logic [CNT_W-1:0]              eff_slices;

	assign divisor = (stripe_size_q == '0) ? aism_pkg::STRIPE_W'(1) : stripe_size_q;

	always_comb begin
		if (slice_count_q == '0) begin
			eff_slices = CNT_W'(1);
		end else if (slice_count_q > aism_pkg::COUNT_W'(MAX_SLICES)) begin
			eff_slices = CNT_W'(MAX_SLICES);
		end else begin
			eff_slices = slice_count_q[CNT_W-1:0];
		end
	end

	// pipe advances unless the output word is held
	logic adv;
	logic out_valid_q;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// stage 1: window check and offset
	aism_pkg::ctl_t        ctl_s1;
	logic [ADDR_WIDTH-1:0] offset_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid     <= in_valid;
			ctl_s1.in_window <= (address >= range_base_q) && (address < range_limit_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			offset_s1 <= address - range_base_q;
		end
	end

	// stripe number
	aism_pkg::ctl_t        ctl_div;
	logic [ADDR_WIDTH-1:0] stripe;

	aism_div_pipe #(
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_in   (ctl_s1),
		.dividend (offset_s1),
		.divisor  (divisor),
		.ctl_out  (ctl_div),
		.quotient (stripe)
	);

	// stage 2: slice key, linear or XOR hashed
	aism_pkg::ctl_t ctl_s2;
	logic [KW-1:0]  key_s2;
	logic [KW-1:0]  stripe_ext;

	assign stripe_ext = KW'(stripe);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_div;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (mode_q == aism_pkg::MODE_XOR) begin
				key_s2 <= stripe_ext ^ (stripe_ext >> hash_shift_q) ^ hash_seed_q;
			end else begin
				key_s2 <= stripe_ext;
			end
		end
	end

	// key modulo slice count
	aism_pkg::ctl_t   ctl_mod;
	logic [REM_W-1:0] slice_rem;

	aism_mod_pipe #(
		.MAX_SLICES(MAX_SLICES)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_in    (ctl_s2),
		.key       (key_s2),
		.modulus   (eff_slices),
		.ctl_out   (ctl_mod),
		.remainder (slice_rem)
	);

	// output register
	logic                         in_window_q;
	logic                         owner_match_q;
	logic [aism_pkg::SLICE_W-1:0] slice_number_q;
	logic [aism_pkg::SLICE_W-1:0] slice_ext;
	logic                         ilv_on;

	assign slice_ext = aism_pkg::SLICE_W'(slice_rem);
	assign ilv_on    = mode_q != aism_pkg::MODE_OFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_mod.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_window_q    <= ctl_mod.in_window;
			owner_match_q  <= ctl_mod.in_window && (!ilv_on || slice_ext == slice_index_q);
			slice_number_q <= (ctl_mod.in_window && ilv_on) ? slice_ext : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign in_window    = in_window_q;
	assign owner_match  = owner_match_q;
	assign slice_number = slice_number_q;

	// ownership needs the window
	a_own_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!owner_match || in_window))
		else $error("owner_match without in_window");

	// a nonzero slice only comes from an interleaved, in-window word
	a_slice_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && slice_number != '0) |-> (in_window && ilv_on))
		else $error("nonzero slice_number outside window or with interleave off");

	// slice stays below the effective slice count
	a_slice_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, slice_number} < (aism_pkg::SLICE_W+1)'(eff_slices)))
		else $error("slice_number not below slice count");

endmodule
